// ===== design/pea_pkg.sv =====
// ----------------------------------------------------------------------------
// pea_pkg
// Shared constants, codes and types of the page extent allocator.
// ----------------------------------------------------------------------------
package pea_pkg;

    localparam int unsigned MAX_EXTENTS_DEF = 64;
    localparam int unsigned ADDR_BITS_DEF   = 48;
    localparam int unsigned PAGE_SHIFT      = 12;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned MTYPE_W  = 4;
    localparam int unsigned COUNT_FW = 37;
    localparam int unsigned ADDR_FW  = 48;
    localparam int unsigned FLAGS_W  = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_BAD   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_ANY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BELOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AT    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

    localparam logic [MTYPE_W-1:0] MT_RT_CODE = 4'd5;
    localparam logic [MTYPE_W-1:0] MT_RT_DATA = 4'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RES    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_BELOW = 2'd1;
    localparam logic [1:0] OP_AT    = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    typedef struct packed {
        logic rotate;
        logic ins;
        logic rem;
        logic we;
    } cell_ctrl_t;

endpackage

// ===== design/pea_ifs.sv =====
// ----------------------------------------------------------------------------
// pea request and response channels
// Valid/ready channels carrying one request item and one response item.
// ----------------------------------------------------------------------------
interface pea_req_if;
    import pea_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [MODE_W-1:0]   alloc_mode;
    logic [MTYPE_W-1:0]  memory_type;
    logic [COUNT_FW-1:0] page_count;
    logic [ADDR_FW-1:0]  address;
    logic [ADDR_FW-1:0]  region_length;
    logic [FLAGS_W-1:0]  region_flags;

    modport source (
        output valid, action, alloc_mode, memory_type, page_count, address,
               region_length, region_flags,
        input  ready
    );
    modport sink (
        input  valid, action, alloc_mode, memory_type, page_count, address,
               region_length, region_flags,
        output ready
    );
endinterface

interface pea_rsp_if;
    import pea_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_FW-1:0]  result_address;

    modport source (
        output valid, status, result_address,
        input  ready
    );
    modport sink (
        input  valid, status, result_address,
        output ready
    );
endinterface

// ===== design/page_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// page_extent_allocator
// Free page extent table kept sorted by address in a ring of cells.
//
// A request item on req (allocate, free pages or add region) gives exactly
// one response item on rsp with a status and, for a successful allocate,
// the base address of the pages taken.
// One item is worked at a time. After acceptance the item passes through
// decode and checks, then the whole ring of MAX_EXTENTS cells rotates
// once past its head cell to find the extent or the neighbors, then come
// one decide and one update step in which all cells shift together for an
// insert or remove. Items rejected in decode skip the scan and go on
// straight to the response.
// req.ready is high only while the block is idle. The response waits in an
// output register until rsp.ready; a held response holds back the next one,
// not the acceptance of the next request.
// Reset empties the table at once (entry count to zero); the cells
// themselves are not cleared.
// ----------------------------------------------------------------------------
module page_extent_allocator #(
    parameter int unsigned MAX_EXTENTS = pea_pkg::MAX_EXTENTS_DEF,
    parameter int unsigned ADDR_BITS   = pea_pkg::ADDR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pea_req_if.sink   req,
    pea_rsp_if.source rsp
);
    import pea_pkg::*;

    localparam int unsigned AW = ADDR_BITS;
    localparam int unsigned BW = AW - PAGE_SHIFT;
    localparam int unsigned CW = BW + 1;
    localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int unsigned UW = $clog2(MAX_EXTENTS + 1);

    localparam logic [AW-1:0] ADDR_MASK = '1;
    localparam logic [CW-1:0] TOTAL     = {1'b1, {BW{1'b0}}};
    localparam logic [UW-1:0] FULL      = UW'(MAX_EXTENTS);
    localparam logic [IW-1:0] LAST      = IW'(MAX_EXTENTS - 1);
    localparam logic [AW-1:0] PAGE_SIZE = AW'(1) << PAGE_SHIFT;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    // control
    logic [2:0]    state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic          out_valid_reg, out_valid_next;

    // latched item
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [MTYPE_W-1:0]  mtype_reg, mtype_next;
    logic [COUNT_FW-1:0] pcnt_reg, pcnt_next;
    logic [AW-1:0]       addr_in_reg, addr_in_next;
    logic [AW-1:0]       len_reg, len_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;

    // working registers
    logic [1:0]          kind_reg, kind_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]       n_reg, n_next;
    logic                nover_reg, nover_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       lim_reg, lim_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       sel_idx_reg, sel_idx_next;
    logic [BW-1:0]       sel_base_reg, sel_base_next;
    logic [CW-1:0]       sel_cnt_reg, sel_cnt_next;
    logic [CW-1:0]       sel_top_reg, sel_top_next;
    logic                nfound_reg, nfound_next;
    logic [IW-1:0]       nidx_reg, nidx_next;
    logic [BW-1:0]       nbase_reg, nbase_next;
    logic [CW-1:0]       ncnt_reg, ncnt_next;
    logic [CW-1:0]       top_reg, top_next;
    logic [CW-1:0]       bottom_reg, bottom_next;
    logic                mprev_reg, mprev_next;
    logic                mnext_reg, mnext_next;
    logic [AW-1:0]       res_reg, res_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_FW-1:0]  out_addr_reg, out_addr_next;

    // cell row
    logic [BW-1:0] cell_base [MAX_EXTENTS];
    logic [CW-1:0] cell_cnt  [MAX_EXTENTS];
    cell_ctrl_t    ctrl;
    logic [IW-1:0] pos, wa;
    logic [BW-1:0] new_base, wr_base;
    logic [CW-1:0] new_cnt, wr_cnt;

    for (genvar k = 0; k < MAX_EXTENTS; k++)
    begin : g_cell
        localparam int unsigned KP = (k == 0) ? 0 : k - 1;
        localparam int unsigned KN = (k == MAX_EXTENTS - 1) ? 0 : k + 1;
        pea_cell #(
            .IDX         (k),
            .MAX_EXTENTS (MAX_EXTENTS),
            .IW          (IW),
            .BW          (BW),
            .CW          (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .pos       (pos),
            .wa        (wa),
            .prev_base (cell_base[KP]),
            .prev_cnt  (cell_cnt[KP]),
            .next_base (cell_base[KN]),
            .next_cnt  (cell_cnt[KN]),
            .new_base  (new_base),
            .new_cnt   (new_cnt),
            .wr_base   (wr_base),
            .wr_cnt    (wr_cnt),
            .base      (cell_base[k]),
            .cnt       (cell_cnt[k])
        );
    end

    // head cell view
    logic [BW-1:0] hb;
    logic [CW-1:0] hc;
    logic [AW-1:0] hb_addr, d;
    logic [CW-1:0] top_raw, top_clamp;
    logic          head_valid, fit_below, head_le;
    logic [BW-1:0] ap;

    assign hb         = cell_base[0];
    assign hc         = cell_cnt[0];
    assign hb_addr    = {hb, {PAGE_SHIFT{1'b0}}};
    assign ap         = addr_reg[AW-1:PAGE_SHIFT];
    assign head_valid = UW'(scan_reg) < used_reg;
    assign d          = lim_reg - hb_addr;
    assign top_raw    = CW'(d >> PAGE_SHIFT) + CW'(&d[PAGE_SHIFT-1:0]);
    assign top_clamp  = (top_raw > hc) ? hc : top_raw;
    assign fit_below  = head_valid && (hc >= n_reg) && (lim_reg >= hb_addr)
                        && (top_raw >= n_reg);
    assign head_le    = hb <= ap;

    // decode helpers
    logic [COUNT_FW-1:0] pcnt_m1;
    logic [AW-1:0]       gap, len_rest;
    logic [CW-1:0]       end_new, ext_end, bottom_d;
    logic [BW-1:0]       up_base;
    logic [CW-1:0]       up_cnt;

    assign pcnt_m1  = pcnt_reg - COUNT_FW'(1);
    assign gap      = (|addr_in_reg[PAGE_SHIFT-1:0])
                      ? PAGE_SIZE - AW'(addr_in_reg[PAGE_SHIFT-1:0]) : '0;
    assign len_rest = len_reg - gap;
    assign end_new  = CW'(ap) + n_reg;
    assign ext_end  = CW'(sel_base_reg) + sel_cnt_reg;
    assign bottom_d = sel_top_reg - n_reg;
    assign up_base  = sel_base_reg + top_reg[BW-1:0];
    assign up_cnt   = sel_cnt_reg - top_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        scan_next       = scan_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        mode_next       = mode_reg;
        mtype_next      = mtype_reg;
        pcnt_next       = pcnt_reg;
        addr_in_next    = addr_in_reg;
        len_next        = len_reg;
        flags_next      = flags_reg;
        kind_next       = kind_reg;
        status_next     = status_reg;
        n_next          = n_reg;
        nover_next      = nover_reg;
        addr_next       = addr_reg;
        lim_next        = lim_reg;
        found_next      = found_reg;
        sel_idx_next    = sel_idx_reg;
        sel_base_next   = sel_base_reg;
        sel_cnt_next    = sel_cnt_reg;
        sel_top_next    = sel_top_reg;
        nfound_next     = nfound_reg;
        nidx_next       = nidx_reg;
        nbase_next      = nbase_reg;
        ncnt_next       = ncnt_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        mprev_next      = mprev_reg;
        mnext_next      = mnext_reg;
        res_next        = res_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        ctrl            = '0;
        pos             = '0;
        wa              = '0;
        new_base        = ap;
        new_cnt         = n_reg;
        wr_base         = sel_base_reg;
        wr_cnt          = sel_cnt_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next     = req.action;
                    mode_next    = req.alloc_mode;
                    mtype_next   = req.memory_type;
                    pcnt_next    = req.page_count;
                    addr_in_next = AW'(req.address);
                    len_next     = AW'(req.region_length);
                    flags_next   = req.region_flags;
                    state_next   = S_PREP;
                end
            end
            S_PREP:
            begin
                kind_next   = OP_NONE;
                status_next = ST_INVALID;
                n_next      = CW'(pcnt_reg);
                nover_next  = 1'b0;
                addr_next   = addr_in_reg;
                lim_next    = ADDR_MASK;
                found_next  = 1'b0;
                nfound_next = 1'b0;
                scan_next   = '0;
                res_next    = '0;
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (mtype_reg != MT_RT_CODE && mtype_reg != MT_RT_DATA)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (pcnt_reg == '0)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (|(pcnt_m1 >> (CW - 1)))
                        begin
                            status_next = ST_NO_RES;
                        end
                        else
                        begin
                            case (mode_reg)
                                MODE_ANY:   kind_next = OP_BELOW;
                                MODE_BELOW:
                                begin
                                    kind_next = OP_BELOW;
                                    lim_next  = addr_in_reg;
                                end
                                MODE_AT:    kind_next = OP_AT;
                                default:    status_next = ST_INVALID;
                            endcase
                        end
                    end
                    ACT_FREE:
                    begin
                        kind_next  = OP_FREE;
                        nover_next = |(pcnt_reg >> CW);
                    end
                    ACT_ADD:
                    begin
                        if (flags_reg != '0 || len_reg < gap)
                        begin
                            status_next = ST_OK;
                        end
                        else
                        begin
                            kind_next = OP_FREE;
                            addr_next = addr_in_reg + gap;
                            n_next    = CW'(len_rest >> PAGE_SHIFT);
                        end
                    end
                    default: status_next = ST_INVALID;
                endcase
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_SCAN;
                if (kind_reg == OP_NONE)
                begin
                    state_next = S_FIN;
                end
                else if (kind_reg == OP_AT && |addr_reg[PAGE_SHIFT-1:0])
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else if (kind_reg == OP_FREE && (|addr_reg[PAGE_SHIFT-1:0]
                         || n_reg == '0 || nover_reg || n_reg > TOTAL - CW'(ap)))
                begin
                    status_next = ST_INVALID;
                    state_next  = S_FIN;
                end
            end
            S_SCAN:
            begin
                ctrl.rotate = 1'b1;
                if (kind_reg == OP_BELOW)
                begin
                    if (fit_below)
                    begin
                        found_next    = 1'b1;
                        sel_idx_next  = scan_reg;
                        sel_base_next = hb;
                        sel_cnt_next  = hc;
                        sel_top_next  = top_clamp;
                    end
                end
                else if (head_valid && head_le)
                begin
                    found_next    = 1'b1;
                    sel_idx_next  = scan_reg;
                    sel_base_next = hb;
                    sel_cnt_next  = hc;
                end
                else if (head_valid && !nfound_reg)
                begin
                    nfound_next = 1'b1;
                    nidx_next   = scan_reg;
                    nbase_next  = hb;
                    ncnt_next   = hc;
                end
                if (scan_reg == LAST)
                begin
                    scan_next  = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            S_DECIDE:
            begin
                state_next  = S_APPLY;
                status_next = ST_OK;
                case (kind_reg)
                    OP_BELOW:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NO_RES;
                            state_next  = S_FIN;
                        end
                        top_next    = sel_top_reg;
                        bottom_next = bottom_d;
                        res_next    = {sel_base_reg, {PAGE_SHIFT{1'b0}}}
                                      + {bottom_d[BW-1:0], {PAGE_SHIFT{1'b0}}};
                    end
                    OP_AT:
                    begin
                        if (!found_reg || ext_end < end_new)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_FIN;
                        end
                        top_next    = end_new - CW'(sel_base_reg);
                        bottom_next = CW'(ap) - CW'(sel_base_reg);
                        res_next    = addr_reg;
                    end
                    default:
                    begin
                        if ((nfound_reg && end_new > CW'(nbase_reg))
                            || (found_reg && ext_end > CW'(ap)))
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_FIN;
                        end
                        mprev_next = found_reg && ext_end == CW'(ap);
                        mnext_next = nfound_reg && end_new == CW'(nbase_reg);
                    end
                endcase
            end
            S_APPLY:
            begin
                state_next = S_FIN;
                if (kind_reg == OP_FREE)
                begin
                    if (mprev_reg && mnext_reg)
                    begin
                        ctrl.we  = 1'b1;
                        wa       = sel_idx_reg;
                        wr_cnt   = sel_cnt_reg + n_reg + ncnt_reg;
                        ctrl.rem = 1'b1;
                        pos      = nidx_reg;
                    end
                    else if (mprev_reg)
                    begin
                        ctrl.we = 1'b1;
                        wa      = sel_idx_reg;
                        wr_cnt  = sel_cnt_reg + n_reg;
                    end
                    else if (mnext_reg)
                    begin
                        ctrl.we = 1'b1;
                        wa      = nidx_reg;
                        wr_base = ap;
                        wr_cnt  = ncnt_reg + n_reg;
                    end
                    else if (used_reg == FULL)
                    begin
                        status_next = ST_NO_RES;
                    end
                    else
                    begin
                        ctrl.ins = 1'b1;
                        pos      = nfound_reg ? nidx_reg : IW'(used_reg);
                    end
                end
                else
                begin
                    if (top_reg < sel_cnt_reg && bottom_reg != '0)
                    begin
                        if (used_reg == FULL)
                        begin
                            status_next = ST_NO_RES;
                        end
                        else
                        begin
                            ctrl.ins = 1'b1;
                            pos      = sel_idx_reg + IW'(1);
                            new_base = up_base;
                            new_cnt  = up_cnt;
                            ctrl.we  = 1'b1;
                            wa       = sel_idx_reg;
                            wr_cnt   = bottom_reg;
                        end
                    end
                    else if (top_reg < sel_cnt_reg)
                    begin
                        ctrl.we = 1'b1;
                        wa      = sel_idx_reg;
                        wr_base = up_base;
                        wr_cnt  = up_cnt;
                    end
                    else if (bottom_reg != '0)
                    begin
                        ctrl.we = 1'b1;
                        wa      = sel_idx_reg;
                        wr_cnt  = bottom_reg;
                    end
                    else
                    begin
                        ctrl.rem = 1'b1;
                        pos      = sel_idx_reg;
                    end
                end
                if (ctrl.ins)
                begin
                    used_next = used_reg + UW'(1);
                end
                else if (ctrl.rem)
                begin
                    used_next = used_reg - UW'(1);
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = (status_reg == ST_OK
                                       && (kind_reg == OP_BELOW || kind_reg == OP_AT))
                                      ? ADDR_FW'(res_reg) : '0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        mode_reg       <= mode_next;
        mtype_reg      <= mtype_next;
        pcnt_reg       <= pcnt_next;
        addr_in_reg    <= addr_in_next;
        len_reg        <= len_next;
        flags_reg      <= flags_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        n_reg          <= n_next;
        nover_reg      <= nover_next;
        addr_reg       <= addr_next;
        lim_reg        <= lim_next;
        found_reg      <= found_next;
        sel_idx_reg    <= sel_idx_next;
        sel_base_reg   <= sel_base_next;
        sel_cnt_reg    <= sel_cnt_next;
        sel_top_reg    <= sel_top_next;
        nfound_reg     <= nfound_next;
        nidx_reg       <= nidx_next;
        nbase_reg      <= nbase_next;
        ncnt_reg       <= ncnt_next;
        top_reg        <= top_next;
        bottom_reg     <= bottom_next;
        mprev_reg      <= mprev_next;
        mnext_reg      <= mnext_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_address = out_addr_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL)
        else $error("extent count above table size");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg == S_PREP)
        else $error("accepted item not decoded");

    a_used_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_APPLY |=> used_reg == $past(used_reg))
        else $error("extent count changed outside update");

    a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SCAN |-> scan_reg == '0)
        else $error("scan index left nonzero");

endmodule

// ===== design/pea_cell.sv =====
// ----------------------------------------------------------------------------
// pea_cell
// One extent slot of the table: rotates, shifts or is written in place.
// ----------------------------------------------------------------------------
module pea_cell #(
    parameter int unsigned IDX         = 0,
    parameter int unsigned MAX_EXTENTS = pea_pkg::MAX_EXTENTS_DEF,
    parameter int unsigned IW          = 6,
    parameter int unsigned BW          = 36,
    parameter int unsigned CW          = 37
) (
    input  logic               clk,
    input  pea_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]      pos,
    input  logic [IW-1:0]      wa,
    input  logic [BW-1:0]      prev_base,
    input  logic [CW-1:0]      prev_cnt,
    input  logic [BW-1:0]      next_base,
    input  logic [CW-1:0]      next_cnt,
    input  logic [BW-1:0]      new_base,
    input  logic [CW-1:0]      new_cnt,
    input  logic [BW-1:0]      wr_base,
    input  logic [CW-1:0]      wr_cnt,
    output logic [BW-1:0]      base,
    output logic [CW-1:0]      cnt
);
    import pea_pkg::*;

    localparam logic [IW-1:0] IDX_V   = IW'(IDX);
    localparam bit            IS_LAST = (IDX == MAX_EXTENTS - 1);

    logic [BW-1:0] base_reg, base_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        base_next = base_reg;
        cnt_next  = cnt_reg;
        if (ctrl.rotate)
        begin
            base_next = next_base;
            cnt_next  = next_cnt;
        end
        else if (ctrl.ins && IDX_V > pos)
        begin
            base_next = prev_base;
            cnt_next  = prev_cnt;
        end
        else if (ctrl.ins && IDX_V == pos)
        begin
            base_next = new_base;
            cnt_next  = new_cnt;
        end
        else if (ctrl.rem && IDX_V >= pos && !IS_LAST)
        begin
            base_next = next_base;
            cnt_next  = next_cnt;
        end
        else if (ctrl.we && IDX_V == wa)
        begin
            base_next = wr_base;
            cnt_next  = wr_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
    end

    assign base = base_reg;
    assign cnt  = cnt_reg;

endmodule
